[src/utlm_pkg.sv]
package utlm_pkg;

    // default build parameters
    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;
    localparam int COUNT_BITS      = 16;

    // fixed field widths
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 8;
    localparam int STATUS_W    = 2;
    localparam int LEVEL_W     = 10;
    localparam int LEVEL_SCALE = 1000;

    // register reset values
    localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd30000;
    localparam logic [CFG_W-1:0] HEIGHT_RST  = 16'd684;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT = 8'd0,
        REG_HEIGHT  = 8'd1
    } t_reg_idx;

    // measurement phase
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } t_phase;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_RISE  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        C_IDLE = 2'd0,
        C_MUL  = 2'd1,
        C_DIV  = 2'd2
    } t_ctrl_state;

    // controller to datapath
    typedef struct packed {
        logic step;
        logic load_direct;
        logic mul;
        logic div;
        logic load_div;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic need_div;
        logic div_last;
    } t_dp_status;

endpackage

[src/utlm_in_if.sv]
interface utlm_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

[src/utlm_out_if.sv]
interface utlm_out_if;
    logic                           valid;
    logic                           ready;
    logic                           trigger_level;
    logic                           busy_res;
    logic                           done_res;
    logic [utlm_pkg::STATUS_W-1:0]  status;
    logic [utlm_pkg::LEVEL_W-1:0]   level_permille;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output status, output level_permille, input ready);
    modport sink (input valid, input trigger_level, input busy_res, input done_res,
                  input status, input level_permille, output ready);
endinterface

[src/utlm_cfg_if.sv]
interface utlm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [utlm_pkg::CFG_IDX_W-1:0] index;
    logic [utlm_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[src/utlm_ctrl.sv]
module utlm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  utlm_pkg::t_dp_status  i_status,
    output logic                  o_in_ready,
    output utlm_pkg::t_dp_cmd     o_cmd
);

    utlm_pkg::t_ctrl_state r_state;
    utlm_pkg::t_ctrl_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= utlm_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            utlm_pkg::C_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.need_div) begin
                        n_state = utlm_pkg::C_MUL;
                    end else begin
                        o_cmd.load_direct = 1'b1;
                    end
                end
            end
            utlm_pkg::C_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = utlm_pkg::C_DIV;
            end
            utlm_pkg::C_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    o_cmd.load_div = 1'b1;
                    n_state        = utlm_pkg::C_IDLE;
                end
            end
            default: begin
                n_state = utlm_pkg::C_IDLE;
            end
        endcase
    end

endmodule

[src/utlm_dp.sv]
module utlm_dp #(
    parameter int TRIG_LOW_TICKS  = utlm_pkg::TRIG_LOW_TICKS,
    parameter int TRIG_HIGH_TICKS = utlm_pkg::TRIG_HIGH_TICKS,
    parameter int COUNT_BITS      = utlm_pkg::COUNT_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  utlm_pkg::t_dp_cmd               i_cmd,
    output utlm_pkg::t_dp_status            o_status,
    input  logic                            i_start_req,
    input  logic                            i_echo_level,
    input  logic                            i_cfg_we,
    input  logic [utlm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [utlm_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic                            o_trigger_level,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic [utlm_pkg::STATUS_W-1:0]   o_status_code,
    output logic [utlm_pkg::LEVEL_W-1:0]    o_level_permille
);

    localparam int CMP_W  = (COUNT_BITS > utlm_pkg::CFG_W) ? COUNT_BITS : utlm_pkg::CFG_W;
    localparam int PROD_W = utlm_pkg::CFG_W + utlm_pkg::LEVEL_W;
    localparam int BIT_W  = $clog2(utlm_pkg::LEVEL_W);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // configuration
    logic [utlm_pkg::CFG_W-1:0]    r_timeout;
    logic [utlm_pkg::CFG_W-1:0]    r_height;

    // measurement state
    utlm_pkg::t_phase              r_phase;
    logic [COUNT_BITS-1:0]         r_ticks;
    logic [COUNT_BITS-1:0]         r_width;

    // level arithmetic
    logic [utlm_pkg::CFG_W-1:0]    r_diff;
    logic [PROD_W-1:0]             r_rem;
    logic [utlm_pkg::LEVEL_W-1:0]  r_quot;
    logic [BIT_W-1:0]              r_bit;

    // result register
    logic                          r_out_valid;
    logic                          r_trig;
    logic                          r_busy;
    logic                          r_done;
    utlm_pkg::t_status             r_stat;
    logic [utlm_pkg::LEVEL_W-1:0]  r_level;

    // tick step
    utlm_pkg::t_phase              cur_phase;
    logic [COUNT_BITS-1:0]         cur_ticks;
    logic [COUNT_BITS-1:0]         ticks_inc;
    utlm_pkg::t_phase              n_phase;
    logic [COUNT_BITS-1:0]         n_ticks;
    logic [COUNT_BITS-1:0]         n_width;
    logic                          tk_trig;
    logic                          tk_done;
    utlm_pkg::t_status             tk_stat;
    logic                          tk_need_div;
    logic                          width_lt_h;
    logic [utlm_pkg::CFG_W-1:0]    diff;

    // divider step
    logic [PROD_W-1:0]             cand;
    logic                          take;
    logic [utlm_pkg::LEVEL_W-1:0]  n_quot;

    assign width_lt_h = CMP_W'(r_width) < CMP_W'(r_height);
    assign diff       = utlm_pkg::CFG_W'(CMP_W'(r_height) - CMP_W'(r_width));
    assign ticks_inc  = cur_ticks + 1'b1;

    // one tick of the ranging sequence
    always_comb begin
        cur_phase = r_phase;
        cur_ticks = r_ticks;
        if (r_phase == utlm_pkg::PH_IDLE && i_start_req) begin
            cur_phase = utlm_pkg::PH_TRIG_LOW;
            cur_ticks = '0;
        end
        n_phase     = cur_phase;
        n_ticks     = cur_ticks;
        n_width     = r_width;
        tk_trig     = 1'b0;
        tk_done     = 1'b0;
        tk_stat     = utlm_pkg::ST_OK;
        tk_need_div = 1'b0;
        case (cur_phase)
            utlm_pkg::PH_TRIG_LOW: begin
                if (CMP_W'(ticks_inc) >= CMP_W'(TRIG_LOW_TICKS)) begin
                    n_phase = utlm_pkg::PH_TRIG_HIGH;
                    n_ticks = '0;
                end else begin
                    n_ticks = ticks_inc;
                end
            end
            utlm_pkg::PH_TRIG_HIGH: begin
                tk_trig = 1'b1;
                if (CMP_W'(ticks_inc) >= CMP_W'(TRIG_HIGH_TICKS)) begin
                    n_phase = utlm_pkg::PH_WAIT_RISE;
                    n_ticks = '0;
                end else begin
                    n_ticks = ticks_inc;
                end
            end
            utlm_pkg::PH_WAIT_RISE: begin
                if (i_echo_level) begin
                    n_phase = utlm_pkg::PH_MEASURE;
                    n_width = COUNT_BITS'(1);
                    n_ticks = '0;
                end else if (CMP_W'(cur_ticks) >= CMP_W'(r_timeout) ||
                             cur_ticks == CNT_MAX) begin
                    n_phase = utlm_pkg::PH_IDLE;
                    n_ticks = '0;
                    tk_done = 1'b1;
                    tk_stat = utlm_pkg::ST_NO_RISE;
                end else begin
                    n_ticks = ticks_inc;
                end
            end
            utlm_pkg::PH_MEASURE: begin
                if (!i_echo_level) begin
                    n_phase     = utlm_pkg::PH_IDLE;
                    tk_done     = 1'b1;
                    tk_need_div = width_lt_h;
                end else if (CMP_W'(r_width) >= CMP_W'(r_timeout) ||
                             r_width == CNT_MAX) begin
                    n_phase = utlm_pkg::PH_IDLE;
                    tk_done = 1'b1;
                    tk_stat = utlm_pkg::ST_TOO_LONG;
                end else begin
                    n_width = r_width + 1'b1;
                end
            end
            default: begin
                n_phase = utlm_pkg::PH_IDLE;
            end
        endcase
    end

    // restoring divide, one quotient bit per cycle, msb first
    always_comb begin
        cand          = PROD_W'(r_height) << r_bit;
        take          = r_rem >= cand;
        n_quot        = r_quot;
        n_quot[r_bit] = take;
    end

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= utlm_pkg::TIMEOUT_RST;
            r_height    <= utlm_pkg::HEIGHT_RST;
            r_phase     <= utlm_pkg::PH_IDLE;
            r_ticks     <= '0;
            r_width     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == utlm_pkg::REG_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == utlm_pkg::REG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
            if (i_cmd.step) begin
                r_phase <= n_phase;
                r_ticks <= n_ticks;
                r_width <= n_width;
            end
            if (i_cmd.load_direct || i_cmd.load_div) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_diff <= diff;
        end
        if (i_cmd.mul) begin
            r_rem  <= PROD_W'(r_diff) * PROD_W'(utlm_pkg::LEVEL_SCALE);
            r_quot <= '0;
            r_bit  <= BIT_W'(utlm_pkg::LEVEL_W - 1);
        end
        if (i_cmd.div) begin
            if (take) begin
                r_rem <= r_rem - cand;
            end
            r_quot <= n_quot;
            r_bit  <= r_bit - 1'b1;
        end
        if (i_cmd.load_direct) begin
            r_trig  <= tk_trig;
            r_busy  <= (n_phase != utlm_pkg::PH_IDLE);
            r_done  <= tk_done;
            r_stat  <= tk_stat;
            r_level <= '0;
        end
        if (i_cmd.load_div) begin
            r_trig  <= 1'b0;
            r_busy  <= 1'b0;
            r_done  <= 1'b1;
            r_stat  <= utlm_pkg::ST_OK;
            r_level <= n_quot;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.need_div = tk_need_div;
    assign o_status.div_last = (r_bit == '0);

    assign o_out_valid      = r_out_valid;
    assign o_trigger_level  = r_trig;
    assign o_busy_res       = r_busy;
    assign o_done_res       = r_done;
    assign o_status_code    = utlm_pkg::STATUS_W'(r_stat);
    assign o_level_permille = r_level;

`ifndef SYNTHESIS
    // the divider only starts once the result register has drained
    a_mul_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul |-> !r_out_valid)
        else $error("divide started with a result still pending");

    // level loads together with the last quotient bit
    a_div_last_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_div |-> (r_bit == '0))
        else $error("level loaded before last quotient bit");

    // quotient never exceeds full scale
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_div |-> (n_quot <= utlm_pkg::LEVEL_W'(utlm_pkg::LEVEL_SCALE)))
        else $error("level above full scale");

    // echo width counts from one once the echo has risen
    a_width_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == utlm_pkg::PH_MEASURE) |-> (r_width != '0))
        else $error("zero echo width while measuring");
`endif

endmodule

[src/ultrasonic_tank_level_meter_unit.sv]
// Ultrasonic tank level meter. Each input word is one microsecond tick with a
// start request and the sampled echo level; each tick gives exactly one result
// word with the trigger drive, busy, done, status and the fill level in tenths
// of a percent. The tick that ends a measurement with an ok status and an
// echo shorter than a nonzero tank height also runs the (height - width) *
// 1000 multiply and then the restoring divider, which yields the ten-bit
// level one quotient bit per cycle; other ticks load their result directly.
// Results sit in an output register; the next tick is taken as soon as that
// register is empty or being read and no divide is running.
// Registers: 0 timeout_us (reset 30000), 1 tank_height_us (reset 684); write
// them only while no tick is in flight. Other indexes are ignored.
module ultrasonic_tank_level_meter_unit #(
    parameter int TRIG_LOW_TICKS  = utlm_pkg::TRIG_LOW_TICKS,
    parameter int TRIG_HIGH_TICKS = utlm_pkg::TRIG_HIGH_TICKS,
    parameter int COUNT_BITS      = utlm_pkg::COUNT_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    utlm_in_if.sink      i_in,
    utlm_out_if.source   o_out,
    utlm_cfg_if.sink     i_cfg
);

    utlm_pkg::t_dp_cmd    cmd;
    utlm_pkg::t_dp_status dp_status;
    logic                 in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    // sequencer
    utlm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (dp_status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // counters, divider and result register
    utlm_dp #(
        .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
        .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (dp_status),
        .i_start_req      (i_in.start_req),
        .i_echo_level     (i_in.echo_level),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_trigger_level  (o_out.trigger_level),
        .o_busy_res       (o_out.busy_res),
        .o_done_res       (o_out.done_res),
        .o_status_code    (o_out.status),
        .o_level_permille (o_out.level_permille)
    );

endmodule
